>>> sv/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg
// Types, constants and calendar helpers shared by the date difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;
    localparam int COUNT_W = DIFF_W - 1;

    // divide by 100 through a reciprocal, exact for every 14-bit year
    localparam int                DIV100_SHIFT = 20;
    localparam logic [YEAR_W-1:0] DIV100_MUL   = 14'd10486;
    localparam int                PROD_W       = 2 * YEAR_W;
    localparam int                QUOT_W       = PROD_W - DIV100_SHIFT;
    localparam int                REM_W        = 7;
    localparam int                QX_W         = YEAR_W + 1;

    localparam logic [REM_W-1:0]   CENTURY       = 7'd100;
    localparam logic [REM_W-1:0]   LAST_OF_CENT  = 7'd99;
    localparam logic [YEAR_W-1:0]  YEAR_MIN      = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
    localparam logic [MONTH_W-1:0] JANUARY       = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY      = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER      = 4'd12;
    localparam logic [DAY_W-1:0]   FIRST_DAY     = 5'd1;
    localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;

    localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // year position inside its century and century count modulo 4
    typedef struct packed {
        logic [REM_W-1:0] mod100;
        logic [1:0]       cent_mod4;
    } t_leap_cnt;

    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
        logic               include_end;
    } t_in_req;

    typedef struct packed {
        logic signed [DIFF_W-1:0] day_difference;
        logic                     bad_date;
    } t_out_rsp;

    function automatic logic is_leap(logic [1:0] year_low, t_leap_cnt cnt);
        logic cent;
        cent = (cnt.mod100 == '0);
        return (cent && (cnt.cent_mod4 == 2'd0)) || (!cent && (year_low == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(logic [MONTH_W-1:0] m, logic leap);
        logic [DAY_W-1:0] len;
        if (m > DECEMBER) begin
            len = '0;
        end else if (m == FEBRUARY && leap) begin
            len = FEB_LEAP_DAYS;
        end else begin
            len = MONTH_LEN[m];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> sv/gdd_day_step.sv
// ----------------------------------------------------------------------------
// gdd_day_step
// Advances a working date by one calendar day and keeps its leap counters.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_day_step
    import gdd_pkg::*;
(
    input  wire t_date     i_date,
    input  wire t_leap_cnt i_cnt,
    output t_date          o_date,
    output t_leap_cnt      o_cnt
);

    logic             w_leap;
    logic [DAY_W-1:0] w_dim;

    assign w_leap = is_leap(i_date.year[1:0], i_cnt);
    assign w_dim  = days_in_month(i_date.month, w_leap);

    always_comb begin
        o_date = i_date;
        o_cnt  = i_cnt;
        if (i_date.day < w_dim) begin
            o_date.day = i_date.day + DAY_W'(1);
        end else begin
            o_date.day = FIRST_DAY;
            if (i_date.month == DECEMBER) begin
                o_date.month = JANUARY;
                o_date.year  = i_date.year + YEAR_W'(1);
                if (i_cnt.mod100 == LAST_OF_CENT) begin
                    o_cnt.mod100    = '0;
                    o_cnt.cent_mod4 = i_cnt.cent_mod4 + 2'd1;
                end else begin
                    o_cnt.mod100 = i_cnt.mod100 + REM_W'(1);
                end
            end else begin
                o_date.month = i_date.month + MONTH_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/gregorian_date_difference.sv
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Signed day count between two Gregorian dates, found by walking a working
// date one day per cycle from the earlier date to the later one.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | request   | i_in_valid / o_in_stall | i_in_req   (t_in_req)
//  out     | result    | o_out_valid / i_out_stall | o_out_rsp (t_out_rsp)
//
//  a request runs S_QUOT and S_REM once for each date, upper date first,
//  then S_STEP walks one day at a time from the lower date, then S_OUT
//  a bad date skips the walk and goes from S_REM straight to S_OUT
//  no new request is taken until the result sits in the output register
//  the output register holds while stalled; reset clears valid and control
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_difference
    import gdd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_req,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output t_out_rsp     o_out_rsp
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_QUOT = 5'b00010,
        S_REM  = 5'b00100,
        S_STEP = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    t_out_rsp             r_out, n_out;
    t_out_rsp             r_res, n_res;
    t_date                r_lo, n_lo;
    t_date                r_hi, n_hi;
    t_date                r_cur, n_cur;
    t_leap_cnt            r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    logic                 r_inc, n_inc;
    logic                 r_bad, n_bad;
    logic                 r_pass, n_pass;
    logic [QUOT_W-1:0]    r_quot, n_quot;
    logic [COUNT_W-1:0]   r_count, n_count;

    t_date                w_first, w_second, w_chk, w_next;
    t_leap_cnt            w_next_cnt, w_chk_cnt;
    logic                 w_accept, w_lt, w_leap, w_ok, w_bad, w_out_free;
    logic [YEAR_W-1:0]    w_year;
    logic [PROD_W-1:0]    w_prod;
    logic [QX_W-1:0]      w_qx100, w_rem_full;
    logic [DIFF_W-1:0]    w_mag;

    gdd_day_step u_step (
        .i_date (r_cur),
        .i_cnt  (r_cnt),
        .o_date (w_next),
        .o_cnt  (w_next_cnt)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_first  = '{year: i_in_req.first_year, month: i_in_req.first_month,
                        day: i_in_req.first_day};
    assign w_second = '{year: i_in_req.second_year, month: i_in_req.second_month,
                        day: i_in_req.second_day};
    assign w_lt     = (w_first < w_second);

    // date check (year, month, day): upper date first, then lower date
    assign w_chk      = r_pass ? r_lo : r_hi;
    assign w_year     = w_chk.year;
    assign w_prod     = PROD_W'(w_year) * PROD_W'(DIV100_MUL);
    assign w_qx100    = QX_W'(r_quot) * QX_W'(CENTURY);
    assign w_rem_full = QX_W'(w_year) - w_qx100;
    assign w_chk_cnt  = '{mod100: w_rem_full[REM_W-1:0], cent_mod4: r_quot[1:0]};
    assign w_leap     = is_leap(w_year[1:0], w_chk_cnt);
    assign w_ok       = (w_year >= YEAR_MIN) && (w_year <= YEAR_MAX)
                     && (w_chk.month >= JANUARY) && (w_chk.month <= DECEMBER)
                     && (w_chk.day >= FIRST_DAY)
                     && (w_chk.day <= days_in_month(w_chk.month, w_leap));
    assign w_bad      = r_bad || !w_ok;

    assign w_mag = {1'b0, r_count} + DIFF_W'(r_inc);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_res       = r_res;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_inc       = r_inc;
        n_bad       = r_bad;
        n_pass      = r_pass;
        n_quot      = r_quot;
        n_count     = r_count;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg   = !w_lt;
                    n_lo    = w_lt ? w_first : w_second;
                    n_hi    = w_lt ? w_second : w_first;
                    n_inc   = i_in_req.include_end;
                    n_bad   = 1'b0;
                    n_pass  = 1'b0;
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                n_quot  = w_prod[PROD_W-1:DIV100_SHIFT];
                n_state = S_REM;
            end
            S_REM: begin
                if (!r_pass) begin
                    n_bad   = w_bad;
                    n_pass  = 1'b1;
                    n_state = S_QUOT;
                end else if (w_bad) begin
                    n_res   = '{day_difference: '0, bad_date: 1'b1};
                    n_state = S_OUT;
                end else begin
                    n_cur   = r_lo;
                    n_cnt   = w_chk_cnt;
                    n_count = '0;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_cur == r_hi) begin
                    n_res.day_difference = r_neg ? (DIFF_W'(0) - w_mag) : w_mag;
                    n_res.bad_date       = 1'b0;
                    n_state              = S_OUT;
                end else begin
                    n_cur   = w_next;
                    n_cnt   = w_next_cnt;
                    n_count = r_count + COUNT_W'(1);
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_res   <= n_res;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_cur   <= n_cur;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_inc   <= n_inc;
        r_bad   <= n_bad;
        r_pass  <= n_pass;
        r_quot  <= n_quot;
        r_count <= n_count;
    end

endmodule

`default_nettype wire
